// File: rtl/irt_pkg.sv
// Package for the integer-to-radix-text converter: widths, register indexes,
// controller/datapath command and status structs, symbol table check.
// No dependencies.
package irt_pkg;

    localparam int VALUE_W      = 32;
    localparam int CHAR_W       = 8;
    localparam int BASE_W       = 5;
    localparam int SYM_W        = 64;
    localparam int DIGIT_W      = 4;
    localparam int DIGIT_SLOTS  = 32;
    localparam int COUNT_W      = 6;
    localparam int SYMBOL_SLOTS = 16;
    localparam int MAX_RADIX    = 16;
    localparam int RADIX_LIMIT  = (MAX_RADIX < SYMBOL_SLOTS) ? MAX_RADIX : SYMBOL_SLOTS;
    // quotient bits resolved per divider step
    localparam int STEP_BITS    = 8;

    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    localparam logic [1:0] REG_BASE_SIZE    = 2'd0;
    localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [BASE_W-1:0] BASE_SIZE_RESET    = 5'd10;
    localparam logic [SYM_W-1:0]  SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [SYM_W-1:0]  SYMBOLS_HIGH_RESET = 64'h0000_0000_0000_3938;

    typedef struct packed {
        logic load;        // take a new value
        logic div_step;    // resolve STEP_BITS quotient bits
        logic div_last;    // final step of a digit: push the remainder
        logic emit_minus;  // load the sign character
        logic emit_digit;  // load the top digit and pop it
    } irt_cmd_t;

    typedef struct packed {
        logic neg;         // value was negative
        logic quo_zero;    // quotient after this step is zero
        logic one_left;    // exactly one digit left on the stack
    } irt_stat_t;

    function automatic logic table_ok(input logic [BASE_W-1:0] base,
                                      input logic [2*SYM_W-1:0] syms);
        logic ok;
        logic [CHAR_W-1:0] ci;
        ok = (int'(base) >= 2) && (int'(base) <= RADIX_LIMIT);
        for (int i = 0; i < SYMBOL_SLOTS; i++) begin
            ci = syms[i*CHAR_W +: CHAR_W];
            if (i < int'(base)) begin
                if (ci == PLUS_CHAR || ci == MINUS_CHAR)
                    ok = 1'b0;
                for (int j = i + 1; j < SYMBOL_SLOTS; j++) begin
                    if (j < int'(base) && syms[j*CHAR_W +: CHAR_W] == ci)
                        ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

// File: rtl/integer_to_radix_text_top.sv
// Top level of the integer-to-radix-text converter: configuration registers,
// table check, output register; instantiates irt_ctrl and irt_dpath. Uses irt_pkg.
//
// Converts one signed 32-bit word into its text in radix base_size, one
// character per output word, most significant digit first, tlast on the final
// character. A negative value gives a leading '-' and then the digits of its
// magnitude (the most negative value works). Zero gives the digit-0 symbol.
// If the symbol table is invalid (radix below 2 or above 16, a '+' or '-'
// among the symbols in use, or two equal symbols) the word is taken and
// nothing is emitted. One word at a time: a word occupies the block until its
// last character is loaded into the output register. The digits come from
// the divider, which resolves 8 quotient bits per cycle for each digit in
// turn; characters then leave one per cycle from the digit stack while the
// output is not stalled. Write configuration only while no word is in
// flight.
module integer_to_radix_text_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata: value[31:0]
    input  logic signed [irt_pkg::VALUE_W-1:0] s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: text_char[7:0]
    output logic [irt_pkg::CHAR_W-1:0]        m_axis_tdata,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [irt_pkg::SYM_W-1:0]         cfg_wdata
);
    import irt_pkg::*;

    logic [BASE_W-1:0] base_size_reg;
    logic [SYM_W-1:0]  symbols_low_reg;
    logic [SYM_W-1:0]  symbols_high_reg;
    logic              table_valid_reg;

    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic              out_valid_reg;
    logic              out_free;

    irt_cmd_t          cmd;
    irt_stat_t         stat;
    logic [DIGIT_W-1:0] top_digit;
    logic [2*SYM_W-1:0] symbols;

    assign symbols = {symbols_high_reg, symbols_low_reg};

    // Configuration registers; writes to an unused index drop silently.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg    <= BASE_SIZE_RESET;
            symbols_low_reg  <= SYMBOLS_LOW_RESET;
            symbols_high_reg <= SYMBOLS_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_SIZE:    base_size_reg    <= cfg_wdata[BASE_W-1:0];
                REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_wdata;
                REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Table check is registered; the controller looks at it in the cycle after
    // accepting a word, so it reflects the configuration as it stood at acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_valid_reg <= 1'b1;
        else
            table_valid_reg <= table_ok(base_size_reg, symbols);
    end

    irt_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .table_valid (table_valid_reg),
        .out_free    (out_free),
        .stat        (stat),
        .cmd         (cmd)
    );

    irt_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (s_axis_tdata),
        .base      (base_size_reg),
        .stat      (stat),
        .top_digit (top_digit)
    );

    // Output register: free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        if (cmd.emit_minus)
        begin
            out_char_next = MINUS_CHAR;
            out_last_next = 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            // look the digit up in the symbol table
            out_char_next = symbols[{top_digit, 3'b000} +: CHAR_W];
            out_last_next = stat.one_left;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_minus || cmd.emit_digit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tvalid = out_valid_reg;

endmodule

// File: rtl/irt_ctrl.sv
// Controller of the integer-to-radix-text converter: sequences accept,
// table check, sign, digit divisions and character emission. Uses irt_pkg.
module irt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              table_valid,
    input  logic              out_free,
    input  irt_pkg::irt_stat_t stat,
    output irt_pkg::irt_cmd_t  cmd
);
    import irt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SIGN  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam int STEPS = VALUE_W / STEP_BITS;
    localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(STEPS - 1);

    logic [2:0]            state_reg, state_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                step_next = '0;
                if (!table_valid)
                    state_next = S_IDLE;
                else if (stat.neg)
                    state_next = S_SIGN;
                else
                    state_next = S_DIV;
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    cmd.emit_minus = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    cmd.div_last = 1'b1;
                    step_next    = '0;
                    if (stat.quo_zero)
                        state_next = S_EMIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (stat.one_left)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/irt_dpath.sv
// Datapath of the integer-to-radix-text converter: magnitude register,
// multi-bit restoring divider by the radix, digit stack. Uses irt_pkg.
module irt_dpath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  irt_pkg::irt_cmd_t             cmd,
    input  logic [irt_pkg::VALUE_W-1:0]   value,
    input  logic [irt_pkg::BASE_W-1:0]    base,
    output irt_pkg::irt_stat_t            stat,
    output logic [irt_pkg::DIGIT_W-1:0]   top_digit
);
    import irt_pkg::*;

    logic [VALUE_W-1:0] div_reg, div_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic               neg_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_dec;
    logic [DIGIT_W-1:0] stack_reg [DIGIT_SLOTS];

    // Restoring division: shift dividend bits into the partial remainder,
    // shift quotient bits in behind them.
    always_comb
    begin
        logic [BASE_W-1:0]  r;
        logic [VALUE_W-1:0] w;
        r = {1'b0, rem_reg};
        w = div_reg;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            r = {r[BASE_W-2:0], w[VALUE_W-1]};
            w = {w[VALUE_W-2:0], 1'b0};
            if (r >= base)
            begin
                r    = r - base;
                w[0] = 1'b1;
            end
        end
        div_next = w;
        rem_next = r[DIGIT_W-1:0];
    end

    assign count_dec = count_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            count_reg <= '0;
        end
        else if (cmd.div_last)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (cmd.emit_digit)
        begin
            count_reg <= count_dec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= value[VALUE_W-1];
            div_reg <= value[VALUE_W-1] ? (~value + 1'b1) : value;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_next;
            // a new digit starts from an empty remainder
            rem_reg <= cmd.div_last ? '0 : rem_next;
        end
        if (cmd.div_last)
            stack_reg[count_reg[COUNT_W-2:0]] <= rem_next;
    end

    assign stat.neg      = neg_reg;
    assign stat.quo_zero = (div_next == '0);
    assign stat.one_left = (count_reg == COUNT_W'(1));
    assign top_digit     = stack_reg[count_dec[COUNT_W-2:0]];

endmodule
